/* rtl/ght_pkg.sv */
// ============================================================================
// ght_pkg
// Shared types and codes of the generational handle table.
// ============================================================================
`default_nettype none

package ght_pkg;

    // Default table sizes
    localparam int DEF_SLOTS = 256;
    localparam int DEF_TYPES = 64;

    // Register reset values
    localparam logic [8:0] OBJ_LIMIT_RST  = 9'd256;
    localparam logic [6:0] TYPE_LIMIT_RST = 7'd64;

    // Configuration register indexes
    localparam logic CFG_OBJ_LIMIT  = 1'b0;
    localparam logic CFG_TYPE_LIMIT = 1'b1;

    // Commands
    localparam logic [2:0] CMD_CREATE   = 3'd0;
    localparam logic [2:0] CMD_VALIDATE = 3'd1;
    localparam logic [2:0] CMD_VAL_ACQ  = 3'd2;
    localparam logic [2:0] CMD_ACQUIRE  = 3'd3;
    localparam logic [2:0] CMD_RELEASE  = 3'd4;
    localparam logic [2:0] CMD_DESTROY  = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE     = 3'd1;
    localparam logic [2:0] ST_CAPACITY     = 3'd2;
    localparam logic [2:0] ST_BAD_HANDLE   = 3'd3;
    localparam logic [2:0] ST_GEN_MISMATCH = 3'd4;
    localparam logic [2:0] ST_REF_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_NOT_ACQUIRED = 3'd6;
    localparam logic [2:0] ST_STILL_REF    = 3'd7;

    // One slot entry
    typedef struct packed {
        logic        active;
        logic [31:0] gen;
        logic [31:0] refs;
    } t_slot_entry;

endpackage

`default_nettype wire

/* rtl/ght_slot_mem.sv */
// ============================================================================
// ght_slot_mem
// Slot store: one write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module ght_slot_mem
    import ght_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(SLOTS)-1:0] i_waddr,
    input  wire t_slot_entry              i_wdata,
    input  wire logic [$clog2(SLOTS)-1:0] i_raddr,
    output t_slot_entry                   o_rdata
);

    t_slot_entry mem [SLOTS];
    t_slot_entry r_rdata;

    // Write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/ght_type_mem.sv */
// ============================================================================
// ght_type_mem
// Type id store: one write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module ght_type_mem
    import ght_pkg::*;
#(
    parameter int TYPES = DEF_TYPES,
    parameter int TAW   = (TYPES > 1) ? $clog2(TYPES) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [TAW-1:0] i_waddr,
    input  wire logic [31:0]    i_wdata,
    input  wire logic [TAW-1:0] i_raddr,
    output logic [31:0]         o_rdata
);

    logic [31:0] mem [TYPES];
    logic [31:0] r_rdata;

    // Write one id, read one id
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/generational_handle_table_unit.sv */
// ============================================================================
// generational_handle_table_unit
// Handle table with generations and reference counts, driven by commands.
// ============================================================================
//
//  channel   signals                                   beat taken when
//  -------   ---------------------------------------   -------------------
//  command   start, busy, i_cmd .. i_ref_amount         start & !busy
//  result    o_valid, o_status .. o_accepted_ops        o_valid (one cycle)
//  config    i_cfg_we, i_cfg_idx, i_cfg_data            i_cfg_we
//
//  Handle commands go from accept through dispatch, one slot memory read and at
//  most one write-back before the next accept. A zero generation, an
//  out-of-range slot, a zero type on create or an unknown command answers from
//  the dispatch state. Create walks the type store (one read per registered type
//  until a match) and then the slot store (one read per slot up to the first
//  free one) before it answers.
//  After reset a clearing pass writes every slot entry with busy high. The
//  receiver cannot stall; each result shows for one cycle.
//
`default_nettype none

module generational_handle_table_unit
    import ght_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS,
    parameter int TYPES = DEF_TYPES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [15:0] i_handle_slot,
    input  wire logic [31:0] i_handle_generation,
    input  wire logic [31:0] i_type_id,
    input  wire logic [31:0] i_ref_amount,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [8:0]  i_cfg_data,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [7:0]       o_out_slot,
    output logic [31:0]      o_out_generation,
    output logic [8:0]       o_needed_objects,
    output logic [6:0]       o_needed_types,
    output logic             o_type_limit_hit,
    output logic [8:0]       o_live_count,
    output logic [6:0]       o_distinct_types,
    output logic [31:0]      o_total_references,
    output logic [31:0]      o_failed_ops,
    output logic [31:0]      o_accepted_ops
);

    localparam int SAW = $clog2(SLOTS);
    localparam int SCW = $clog2(SLOTS + 1);
    localparam int TAW = (TYPES > 1) ? $clog2(TYPES) : 1;
    localparam int TCW = $clog2(TYPES + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_HRD  = 4'd3;
    localparam logic [3:0] S_HEX  = 4'd4;
    localparam logic [3:0] S_TRD  = 4'd5;
    localparam logic [3:0] S_TCMP = 4'd6;
    localparam logic [3:0] S_SRD  = 4'd7;
    localparam logic [3:0] S_SCMP = 4'd8;
    localparam logic [3:0] S_CFIN = 4'd9;

    // Control state
    logic [3:0]     r_state, n_state;
    logic [SAW-1:0] r_clr, n_clr;
    logic [8:0]     r_obj_lim;
    logic [6:0]     r_type_lim;
    logic [SCW-1:0] r_alive, n_alive;
    logic [TCW-1:0] r_tcount, n_tcount;
    logic [31:0]    r_sum, n_sum;
    logic [31:0]    r_fail, n_fail;
    logic [31:0]    r_succ, n_succ;
    logic           r_done, n_done;

    // Command and scan payload
    logic [2:0]     r_cmd, n_cmd;
    logic [15:0]    r_hslot, n_hslot;
    logic [31:0]    r_hgen, n_hgen;
    logic [31:0]    r_tid, n_tid;
    logic [31:0]    r_amt, n_amt;
    logic [TCW-1:0] r_ti, n_ti;
    logic [SCW-1:0] r_si, n_si;
    logic           r_known, n_known;
    logic           r_found, n_found;
    logic [31:0]    r_sgen, n_sgen;

    // Result payload
    logic [2:0]     r_status, n_status;
    logic [7:0]     r_oslot, n_oslot;
    logic [31:0]    r_ogen, n_ogen;
    logic [8:0]     r_nobj, n_nobj;
    logic [6:0]     r_ntyp, n_ntyp;
    logic           r_thit, n_thit;

    // Memory ports
    logic           slot_we;
    logic [SAW-1:0] slot_waddr;
    t_slot_entry    slot_wdata;
    logic [SAW-1:0] slot_raddr;
    t_slot_entry    slot_rdata;
    logic           type_we;
    logic [TAW-1:0] type_waddr;
    logic [TAW-1:0] type_raddr;
    logic [31:0]    type_rdata;

    // Working values
    logic [SCW-1:0] obj_cap;
    logic [TCW-1:0] type_cap;
    logic           fin;
    logic           fin_rec;
    logic [2:0]     fin_st;
    logic [2:0]     hst;
    logic [TCW:0]   need_types;
    logic [31:0]    new_gen;

    ght_slot_mem #(
        .SLOTS(SLOTS)
    ) u_slot_mem (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_raddr(slot_raddr),
        .o_rdata(slot_rdata)
    );

    ght_type_mem #(
        .TYPES(TYPES),
        .TAW  (TAW)
    ) u_type_mem (
        .i_clk  (i_clk),
        .i_we   (type_we),
        .i_waddr(type_waddr),
        .i_wdata(r_tid),
        .i_raddr(type_raddr),
        .o_rdata(type_rdata)
    );

    // Clamp limits to table sizes
    assign obj_cap  = (32'(r_obj_lim) > 32'(SLOTS)) ? SCW'(SLOTS) : SCW'(r_obj_lim);
    assign type_cap = (32'(r_type_lim) > 32'(TYPES)) ? TCW'(TYPES) : TCW'(r_type_lim);

    // Check the handle against the entry read back
    always_comb begin
        if (slot_rdata.gen == 32'd0) begin
            hst = ST_BAD_HANDLE;
        end else if (slot_rdata.gen != r_hgen) begin
            hst = ST_GEN_MISMATCH;
        end else if (!slot_rdata.active) begin
            hst = ST_BAD_HANDLE;
        end else begin
            hst = ST_OK;
        end
    end

    assign need_types = {1'b0, r_tcount} + {{TCW{1'b0}}, !r_known};
    assign new_gen    = (r_sgen == 32'd0) ? 32'd1 : r_sgen;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_alive  = r_alive;
        n_tcount = r_tcount;
        n_sum    = r_sum;
        n_fail   = r_fail;
        n_succ   = r_succ;
        n_done   = 1'b0;
        n_cmd    = r_cmd;
        n_hslot  = r_hslot;
        n_hgen   = r_hgen;
        n_tid    = r_tid;
        n_amt    = r_amt;
        n_ti     = r_ti;
        n_si     = r_si;
        n_known  = r_known;
        n_found  = r_found;
        n_sgen   = r_sgen;
        n_status = r_status;
        n_oslot  = r_oslot;
        n_ogen   = r_ogen;
        n_nobj   = r_nobj;
        n_ntyp   = r_ntyp;
        n_thit   = r_thit;
        fin      = 1'b0;
        fin_rec  = 1'b0;
        fin_st   = ST_OK;
        slot_we    = 1'b0;
        slot_waddr = r_hslot[SAW-1:0];
        slot_wdata = '0;
        slot_raddr = r_hslot[SAW-1:0];
        type_we    = 1'b0;
        type_waddr = r_tcount[TAW-1:0];
        type_raddr = r_ti[TAW-1:0];

        unique case (r_state)
            S_CLR: begin
                // Zero one slot entry per cycle
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (32'(r_clr) == SLOTS - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_hslot = i_handle_slot;
                    n_hgen  = i_handle_generation;
                    n_tid   = i_type_id;
                    n_amt   = i_ref_amount;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_cmd == CMD_CREATE) begin
                    if (r_tid == 32'd0) begin
                        fin     = 1'b1;
                        fin_rec = 1'b1;
                        fin_st  = ST_BAD_TYPE;
                    end else begin
                        n_ti    = '0;
                        n_si    = '0;
                        n_known = 1'b0;
                        n_state = S_TRD;
                    end
                end else if (r_cmd == CMD_VALIDATE || r_cmd == CMD_VAL_ACQ ||
                             r_cmd == CMD_ACQUIRE || r_cmd == CMD_RELEASE ||
                             r_cmd == CMD_DESTROY) begin
                    if (r_hgen == 32'd0 || 32'(r_hslot) >= 32'(obj_cap)) begin
                        fin     = 1'b1;
                        fin_rec = (r_cmd != CMD_VAL_ACQ);
                        fin_st  = ST_BAD_HANDLE;
                    end else begin
                        n_state = S_HRD;
                    end
                end else begin
                    // Unknown command: no state change, nothing recorded
                    fin    = 1'b1;
                    fin_st = ST_BAD_HANDLE;
                end
            end
            S_HRD: begin
                n_state = S_HEX;
            end
            S_HEX: begin
                fin     = 1'b1;
                fin_rec = (r_cmd != CMD_VAL_ACQ);
                fin_st  = hst;
                if (hst == ST_OK) begin
                    if (r_cmd == CMD_VAL_ACQ) begin
                        if (r_amt != 32'd0 && r_amt > ~slot_rdata.refs) begin
                            fin_st = ST_REF_OVERFLOW;
                        end
                    end else if (r_cmd == CMD_ACQUIRE) begin
                        if (slot_rdata.refs == 32'hFFFF_FFFF) begin
                            fin_st = ST_REF_OVERFLOW;
                        end else begin
                            slot_we         = 1'b1;
                            slot_wdata      = slot_rdata;
                            slot_wdata.refs = slot_rdata.refs + 32'd1;
                            n_sum           = r_sum + 32'd1;
                        end
                    end else if (r_cmd == CMD_RELEASE) begin
                        if (slot_rdata.refs == 32'd0) begin
                            fin_st = ST_NOT_ACQUIRED;
                        end else begin
                            slot_we         = 1'b1;
                            slot_wdata      = slot_rdata;
                            slot_wdata.refs = slot_rdata.refs - 32'd1;
                            n_sum           = r_sum - 32'd1;
                        end
                    end else if (r_cmd == CMD_DESTROY) begin
                        if (slot_rdata.refs != 32'd0) begin
                            fin_st = ST_STILL_REF;
                        end else begin
                            // Retire the slot and advance its generation
                            slot_we           = 1'b1;
                            slot_wdata.active = 1'b0;
                            slot_wdata.refs   = 32'd0;
                            slot_wdata.gen    = (slot_rdata.gen == 32'hFFFF_FFFF) ?
                                                32'd1 : slot_rdata.gen + 32'd1;
                            n_alive           = r_alive - 1'b1;
                        end
                    end
                end
            end
            S_TRD: begin
                if (r_ti >= r_tcount) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_TCMP;
                end
            end
            S_TCMP: begin
                if (type_rdata == r_tid) begin
                    n_known = 1'b1;
                    n_state = S_SRD;
                end else begin
                    n_ti    = r_ti + 1'b1;
                    n_state = S_TRD;
                end
            end
            S_SRD: begin
                slot_raddr = r_si[SAW-1:0];
                if (r_alive >= obj_cap || r_si >= obj_cap) begin
                    n_found = 1'b0;
                    n_state = S_CFIN;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (!slot_rdata.active) begin
                    n_found = 1'b1;
                    n_sgen  = slot_rdata.gen;
                    n_state = S_CFIN;
                end else begin
                    n_si    = r_si + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_CFIN: begin
                fin     = 1'b1;
                fin_rec = 1'b1;
                if (!r_found) begin
                    fin_st = ST_CAPACITY;
                end else if (need_types > {1'b0, type_cap}) begin
                    fin_st = ST_CAPACITY;
                end else begin
                    // Register the type if it is new and occupy the free slot
                    fin_st = ST_OK;
                    if (!r_known && 32'(r_tcount) < TYPES) begin
                        type_we  = 1'b1;
                        n_tcount = r_tcount + 1'b1;
                    end
                    slot_we           = 1'b1;
                    slot_waddr        = r_si[SAW-1:0];
                    slot_wdata.active = 1'b1;
                    slot_wdata.gen    = new_gen;
                    slot_wdata.refs   = r_amt;
                    n_alive           = r_alive + 1'b1;
                    n_sum             = r_sum + r_amt;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Close the command and load the result beat
        if (fin) begin
            n_state  = S_IDLE;
            n_done   = 1'b1;
            n_status = fin_st;
            n_oslot  = '0;
            n_ogen   = '0;
            n_nobj   = '0;
            n_ntyp   = '0;
            n_thit   = 1'b0;
            if (r_state == S_CFIN) begin
                n_nobj = 9'(32'(r_alive) + 32'd1);
                n_ntyp = 7'(need_types);
                n_thit = r_found && (fin_st == ST_CAPACITY);
                if (fin_st == ST_OK) begin
                    n_oslot = 8'(r_si);
                    n_ogen  = new_gen;
                end
            end
            if (fin_rec) begin
                if (fin_st == ST_OK) begin
                    n_succ = r_succ + 32'd1;
                end else begin
                    n_fail = r_fail + 32'd1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_obj_lim  <= OBJ_LIMIT_RST;
            r_type_lim <= TYPE_LIMIT_RST;
            r_alive    <= '0;
            r_tcount   <= '0;
            r_sum      <= '0;
            r_fail     <= '0;
            r_succ     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_alive  <= n_alive;
            r_tcount <= n_tcount;
            r_sum    <= n_sum;
            r_fail   <= n_fail;
            r_succ   <= n_succ;
            r_done   <= n_done;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OBJ_LIMIT) begin
                    r_obj_lim <= i_cfg_data;
                end else begin
                    r_type_lim <= i_cfg_data[6:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_hslot  <= n_hslot;
        r_hgen   <= n_hgen;
        r_tid    <= n_tid;
        r_amt    <= n_amt;
        r_ti     <= n_ti;
        r_si     <= n_si;
        r_known  <= n_known;
        r_found  <= n_found;
        r_sgen   <= n_sgen;
        r_status <= n_status;
        r_oslot  <= n_oslot;
        r_ogen   <= n_ogen;
        r_nobj   <= n_nobj;
        r_ntyp   <= n_ntyp;
        r_thit   <= n_thit;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_done;
    assign o_status           = r_status;
    assign o_out_slot         = r_oslot;
    assign o_out_generation   = r_ogen;
    assign o_needed_objects   = r_nobj;
    assign o_needed_types     = r_ntyp;
    assign o_type_limit_hit   = r_thit;
    assign o_live_count       = 9'(r_alive);
    assign o_distinct_types   = 7'(r_tcount);
    assign o_total_references = r_sum;
    assign o_failed_ops       = r_fail;
    assign o_accepted_ops     = r_succ;

`ifndef NO_ASSERTIONS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held two cycles");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_alive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_alive) <= SLOTS)
        else $error("live count beyond slot table");

    a_types_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tcount) <= TYPES)
        else $error("type count beyond type table");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ============================================================================
// testbench
// Command-level check of the generational handle table. Directed commands
// cover the error codes and edge cases. Mostly well-formed random handle
// traffic then runs under several capacity settings. Every result beat is
// compared against a local model of the slot and type tables.
// ============================================================================
`default_nettype none

module testbench
    import ght_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Result beat as seen on the output ports
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_slot;
        logic [31:0] out_gen;
        logic [8:0]  need_obj;
        logic [6:0]  need_typ;
        logic        type_hit;
        logic [8:0]  live;
        logic [6:0]  types;
        logic [31:0] refs;
        logic [31:0] fails;
        logic [31:0] oks;
    } t_handle_result;

    // One directed command, with an optional hand-typed status
    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] slot;
        logic [31:0] gen;
        logic [31:0] tid;
        logic [31:0] amt;
        logic        typed;
        logic [2:0]  st;
    } t_cmd_row;

    localparam int NUM_DIRECTED = 24;
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 800;
    localparam int CYCLE_LIMIT  = 4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_cmd;
    logic [15:0] i_handle_slot;
    logic [31:0] i_handle_generation;
    logic [31:0] i_type_id;
    logic [31:0] i_ref_amount;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [8:0]  i_cfg_data;
    logic        o_valid;
    wire t_handle_result got;

    generational_handle_table_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cmd               (i_cmd),
        .i_handle_slot       (i_handle_slot),
        .i_handle_generation (i_handle_generation),
        .i_type_id           (i_type_id),
        .i_ref_amount        (i_ref_amount),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .o_status            (got.status),
        .o_out_slot          (got.out_slot),
        .o_out_generation    (got.out_gen),
        .o_needed_objects    (got.need_obj),
        .o_needed_types      (got.need_typ),
        .o_type_limit_hit    (got.type_hit),
        .o_live_count        (got.live),
        .o_distinct_types    (got.types),
        .o_total_references  (got.refs),
        .o_failed_ops        (got.fails),
        .o_accepted_ops      (got.oks)
    );

    // Model state of the table
    logic [8:0]  mdl_obj_limit;
    logic [6:0]  mdl_type_limit;
    logic        mdl_active [DEF_SLOTS];
    logic [31:0] mdl_gen    [DEF_SLOTS];
    logic [31:0] mdl_refs   [DEF_SLOTS];
    logic [31:0] mdl_types  [DEF_TYPES];
    logic [8:0]  mdl_alive;
    logic [6:0]  mdl_type_cnt;
    logic [31:0] mdl_ref_sum;
    logic [31:0] mdl_fails;
    logic [31:0] mdl_oks;

    t_handle_result pending_results [$];
    int          mismatches;
    int          cycles;
    logic [31:0] type_pool [8];
    logic        quiet;

    t_cmd_row directed [NUM_DIRECTED] = '{
        '{CMD_VALIDATE, 16'd0, 32'd1, 32'd0, 32'd0, 1'b1, ST_BAD_HANDLE},
        '{CMD_CREATE, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_BAD_TYPE},
        '{3'd6, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_BAD_HANDLE},
        '{3'd7, 16'd0, 32'd1, 32'd1, 32'd1, 1'b1, ST_BAD_HANDLE},
        '{CMD_CREATE, 16'd0, 32'd0, 32'hFFFFFFFF, 32'd0, 1'b0, ST_OK},
        '{CMD_CREATE, 16'd0, 32'd0, 32'd1, 32'hFFFFFFFF, 1'b0, ST_OK},
        '{CMD_VALIDATE, 16'd0, 32'd1, 32'd0, 32'd0, 1'b1, ST_OK},
        '{CMD_VALIDATE, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_BAD_HANDLE},
        '{CMD_VALIDATE, 16'hFFFF, 32'd1, 32'd0, 32'd0, 1'b1, ST_BAD_HANDLE},
        '{CMD_VALIDATE, 16'd0, 32'd2, 32'd0, 32'd0, 1'b1, ST_GEN_MISMATCH},
        '{CMD_VAL_ACQ, 16'd1, 32'd1, 32'd0, 32'd1, 1'b1, ST_REF_OVERFLOW},
        '{CMD_VAL_ACQ, 16'd1, 32'd1, 32'd0, 32'd0, 1'b1, ST_OK},
        '{CMD_ACQUIRE, 16'd1, 32'd1, 32'd0, 32'd0, 1'b1, ST_REF_OVERFLOW},
        '{CMD_RELEASE, 16'd0, 32'd1, 32'd0, 32'd0, 1'b1, ST_NOT_ACQUIRED},
        '{CMD_DESTROY, 16'd1, 32'd1, 32'd0, 32'd0, 1'b1, ST_STILL_REF},
        '{CMD_ACQUIRE, 16'd0, 32'd1, 32'd0, 32'd0, 1'b0, ST_OK},
        '{CMD_DESTROY, 16'd0, 32'd1, 32'd0, 32'd0, 1'b1, ST_STILL_REF},
        '{CMD_RELEASE, 16'd0, 32'd1, 32'd0, 32'd0, 1'b0, ST_OK},
        '{CMD_DESTROY, 16'd0, 32'd1, 32'd0, 32'd0, 1'b0, ST_OK},
        '{CMD_VALIDATE, 16'd0, 32'd1, 32'd0, 32'd0, 1'b1, ST_GEN_MISMATCH},
        '{CMD_VALIDATE, 16'd0, 32'd2, 32'd0, 32'd0, 1'b1, ST_BAD_HANDLE},
        '{CMD_CREATE, 16'd0, 32'd0, 32'h80000000, 32'd5, 1'b0, ST_OK},
        '{CMD_VAL_ACQ, 16'd0, 32'd2, 32'd0, 32'hFFFFFFFA, 1'b0, ST_OK},
        '{CMD_VAL_ACQ, 16'd0, 32'd2, 32'd0, 32'hFFFFFFFB, 1'b1, ST_REF_OVERFLOW}
    };

    int phase_obj  [NUM_PHASES] = '{256, 4, 511, 0, 37, 256};
    int phase_type [NUM_PHASES] = '{64, 2, 127, 0, 5, 64};
    int phase_len  [NUM_PHASES] = '{250, 120, 200, 40, 90, 150};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int obj_cap();
        return (mdl_obj_limit > DEF_SLOTS) ? DEF_SLOTS : int'(mdl_obj_limit);
    endfunction

    function automatic int type_cap();
        return (mdl_type_limit > DEF_TYPES) ? DEF_TYPES : int'(mdl_type_limit);
    endfunction

    function automatic logic [2:0] mdl_check_handle(logic [15:0] slot, logic [31:0] gen);
        if (gen == 0 || int'(slot) >= obj_cap()) return ST_BAD_HANDLE;
        if (mdl_gen[slot] == 0) return ST_BAD_HANDLE;
        if (mdl_gen[slot] != gen) return ST_GEN_MISMATCH;
        if (!mdl_active[slot]) return ST_BAD_HANDLE;
        return ST_OK;
    endfunction

    // Apply one command to the model and return the beat it should produce
    function automatic t_handle_result table_step(logic [2:0] cmd, logic [15:0] slot,
                                                  logic [31:0] gen, logic [31:0] tid,
                                                  logic [31:0] amt);
        t_handle_result r;
        logic known;
        int free_idx;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_CREATE: begin
                if (tid == 0) begin
                    r.status = ST_BAD_TYPE;
                end else begin
                    known = 1'b0;
                    for (int i = 0; i < int'(mdl_type_cnt); i++)
                        if (mdl_types[i] == tid) known = 1'b1;
                    r.need_obj = mdl_alive + 9'd1;
                    r.need_typ = mdl_type_cnt + (known ? 7'd0 : 7'd1);
                    free_idx = -1;
                    if (int'(mdl_alive) < obj_cap())
                        for (int i = 0; i < obj_cap(); i++)
                            if (free_idx < 0 && !mdl_active[i]) free_idx = i;
                    if (free_idx < 0) begin
                        r.status = ST_CAPACITY;
                    end else if (int'(r.need_typ) > type_cap()) begin
                        r.status = ST_CAPACITY;
                        r.type_hit = 1'b1;
                    end else begin
                        if (!known && mdl_type_cnt < DEF_TYPES) begin
                            mdl_types[mdl_type_cnt] = tid;
                            mdl_type_cnt++;
                        end
                        if (mdl_gen[free_idx] == 0) mdl_gen[free_idx] = 32'd1;
                        mdl_refs[free_idx] = amt;
                        mdl_active[free_idx] = 1'b1;
                        mdl_alive++;
                        mdl_ref_sum += amt;
                        r.out_slot = free_idx[7:0];
                        r.out_gen = mdl_gen[free_idx];
                    end
                end
            end
            CMD_VALIDATE: r.status = mdl_check_handle(slot, gen);
            CMD_VAL_ACQ: begin
                r.status = mdl_check_handle(slot, gen);
                if (r.status == ST_OK && amt != 0 && amt > 32'hFFFFFFFF - mdl_refs[slot])
                    r.status = ST_REF_OVERFLOW;
            end
            CMD_ACQUIRE: begin
                r.status = mdl_check_handle(slot, gen);
                if (r.status == ST_OK) begin
                    if (mdl_refs[slot] == 32'hFFFFFFFF) begin
                        r.status = ST_REF_OVERFLOW;
                    end else begin
                        mdl_refs[slot]++;
                        mdl_ref_sum++;
                    end
                end
            end
            CMD_RELEASE: begin
                r.status = mdl_check_handle(slot, gen);
                if (r.status == ST_OK) begin
                    if (mdl_refs[slot] == 0) begin
                        r.status = ST_NOT_ACQUIRED;
                    end else begin
                        mdl_refs[slot]--;
                        mdl_ref_sum--;
                    end
                end
            end
            CMD_DESTROY: begin
                r.status = mdl_check_handle(slot, gen);
                if (r.status == ST_OK) begin
                    if (mdl_refs[slot] != 0) begin
                        r.status = ST_STILL_REF;
                    end else begin
                        mdl_active[slot] = 1'b0;
                        mdl_gen[slot] = (mdl_gen[slot] == 32'hFFFFFFFF) ? 32'd1
                                                                        : mdl_gen[slot] + 1;
                        mdl_alive--;
                    end
                end
            end
            default: r.status = ST_BAD_HANDLE;
        endcase
        // validate_acquire and unknown commands leave the counters alone
        if (cmd <= CMD_DESTROY && cmd != CMD_VAL_ACQ) begin
            if (r.status == ST_OK) mdl_oks++;
            else mdl_fails++;
        end
        r.live = mdl_alive;
        r.types = mdl_type_cnt;
        r.refs = mdl_ref_sum;
        r.fails = mdl_fails;
        r.oks = mdl_oks;
        return r;
    endfunction

    // Drive one command beat, wait for it to be taken, log its prediction
    task automatic issue_cmd(logic [2:0] cmd, logic [15:0] slot, logic [31:0] gen,
                             logic [31:0] tid, logic [31:0] amt, logic typed,
                             logic [2:0] st);
        t_handle_result r;
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = cmd;
        i_handle_slot = slot;
        i_handle_generation = gen;
        i_type_id = tid;
        i_ref_amount = amt;
        // busy only moves at rising edges, so a low value here holds for the next one
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        r = table_step(cmd, slot, gen, tid, amt);
        if (typed) r.status = st;
        pending_results.push_back(r);
    endtask

    // Let the table go idle, then program both limits
    task automatic set_limits(int obj, int typ);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = CFG_OBJ_LIMIT;
        i_cfg_data = obj[8:0];
        @(negedge i_clk);
        i_cfg_idx = CFG_TYPE_LIMIT;
        i_cfg_data = {2'b00, typ[6:0]};
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        mdl_obj_limit = obj[8:0];
        mdl_type_limit = typ[6:0];
    endtask

    // Build one random command, mostly aimed at live handles
    task automatic random_cmd();
        logic [2:0]  cmd;
        logic [15:0] slot;
        logic [31:0] gen;
        logic [31:0] tid;
        logic [31:0] amt;
        int pick;
        int base;
        int found;
        pick = $urandom_range(0, 99);
        cmd = (pick < 25) ? CMD_CREATE : (pick < 33) ? CMD_VALIDATE :
              (pick < 40) ? CMD_VAL_ACQ : (pick < 52) ? CMD_ACQUIRE :
              (pick < 77) ? CMD_RELEASE : (pick < 92) ? CMD_DESTROY : 3'($urandom_range(0, 7));
        // type id: mostly a repeat from a small pool
        pick = $urandom_range(0, 99);
        tid = (pick < 75) ? type_pool[$urandom_range(0, 7)] : (pick < 97) ? $urandom : 32'd0;
        // amount: mostly small, sometimes near the top
        pick = $urandom_range(0, 99);
        amt = (pick < 70) ? 32'($urandom_range(0, 2)) : (pick < 80) ? $urandom :
              (pick < 90) ? 32'hFFFFFFFF - $urandom_range(0, 2) : 32'd0;
        // handle: mostly a live one
        found = -1;
        base = $urandom_range(0, DEF_SLOTS - 1);
        for (int k = 0; k < DEF_SLOTS; k++)
            if (found < 0 && mdl_active[(base + k) % DEF_SLOTS]
                && (base + k) % DEF_SLOTS < obj_cap())
                found = (base + k) % DEF_SLOTS;
        pick = $urandom_range(0, 99);
        if (found >= 0 && pick < 85) begin
            slot = found[15:0];
            gen = mdl_gen[found];
        end else begin
            slot = (pick < 95) ? 16'($urandom_range(0, 300)) : 16'($urandom);
            pick = $urandom_range(0, 3);
            gen = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom :
                  (slot < DEF_SLOTS) ? mdl_gen[slot[7:0]] + pick - 2 : 32'd1;
        end
        issue_cmd(cmd, slot, gen, tid, amt, 1'b0, ST_OK);
    endtask

    // Check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_handle_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %p", got);
            end else begin
                e = pending_results.pop_front();
                if (got !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch\n  expected %p\n  actual   %p", e, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int items;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = CMD_VALIDATE;
        i_handle_slot = '0;
        i_handle_generation = '0;
        i_type_id = '0;
        i_ref_amount = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_OBJ_LIMIT;
        i_cfg_data = '0;
        mdl_obj_limit = OBJ_LIMIT_RST;
        mdl_type_limit = TYPE_LIMIT_RST;
        for (int i = 0; i < DEF_SLOTS; i++) begin
            mdl_active[i] = 1'b0;
            mdl_gen[i] = '0;
            mdl_refs[i] = '0;
        end
        for (int i = 0; i < DEF_TYPES; i++) mdl_types[i] = '0;
        mdl_alive = '0;
        mdl_type_cnt = '0;
        mdl_ref_sum = '0;
        mdl_fails = '0;
        mdl_oks = '0;
        for (int i = 0; i < 8; i++) type_pool[i] = $urandom | 32'd1;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed commands at the reset limits
        for (int i = 0; i < NUM_DIRECTED; i++)
            issue_cmd(directed[i].cmd, directed[i].slot, directed[i].gen, directed[i].tid,
                      directed[i].amt, directed[i].typed, directed[i].st);

        // Random traffic, one limit setting per phase
        items = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_limits(phase_obj[p], phase_type[p]);
            for (int n = 0; n < phase_len[p]; n++) begin
                quiet = (items >= 300 && items < 420);
                random_cmd();
                items++;
            end
        end
        quiet = 1'b0;

        // Drain
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* generational_handle_table_unit.f */
rtl/ght_pkg.sv
rtl/ght_slot_mem.sv
rtl/ght_type_mem.sv
rtl/generational_handle_table_unit.sv
tb/testbench.sv
